// ----- src/btl_pkg.sv -----
// btl_pkg: types and character codes shared by the bracket token lexer
// no dependencies
package btl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_TOKEN   = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TOKEN   = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_UNKNOWN = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_e;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChRBrack  = 8'h5D;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;

  localparam logic [15:0] LineMax = 16'hFFFF;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_out;
    logic [15:0] line;
    logic        token_last;
    logic        run_last;
  } out_item_t;

  // up to two results produced by one input byte
  typedef struct packed {
    logic      valid0;
    logic      valid1;
    out_item_t res0;
    out_item_t res1;
  } step_res_t;

endpackage

// ----- src/btl_lexer.sv -----
// btl_lexer: lexer state registers and the per-byte next-state and result logic
// depends on btl_pkg
module btl_lexer import btl_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output step_res_t res_o
);

  mode_e       mode_q, mode_d;
  logic        brace_q, brace_d;
  logic [5:0]  tok_len_q, tok_len_d;
  logic [15:0] line_q, line_d;
  logic [15:0] tok_line_q, tok_line_d;

  logic [7:0]  b;
  logic        fin;
  logic        is_ws, is_nl, too_long, closes;
  logic [15:0] line_inc;
  // line count after this byte, before the end-of-buffer reset
  logic [15:0] line_step;

  assign b        = item_i.byte_in;
  assign fin      = item_i.buffer_end;
  assign is_nl    = (b == ChNewline);
  assign is_ws    = (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  assign too_long = (tok_len_q >= 6'(MAX_TOKEN_LEN));
  assign closes   = (b == (brace_q ? ChRBrace : ChRParen));
  assign line_inc = (line_q == LineMax) ? line_q : line_q + 16'd1;

  // byte-level result and error, before the end-of-buffer handling
  logic        a_valid, err;
  kind_e       a_kind;
  logic [7:0]  a_byte;
  logic [15:0] a_line;
  logic        a_last;

  always_comb begin
    a_valid = 1'b0;
    err     = 1'b0;
    a_kind  = KIND_TOKEN;
    a_byte  = b;
    a_line  = line_q;
    a_last  = 1'b0;
    unique case (mode_q)
      MODE_IDLE: begin
        if (is_ws || b == ChComma) begin
          a_valid = 1'b0;
        end else if (b == ChSlash) begin
          if (fin) begin
            a_valid = 1'b1;
            a_kind  = KIND_UNKNOWN;
            err     = 1'b1;
          end
        end else if (b == ChLBrack || b == ChRBrack) begin
          a_valid = 1'b1;
          a_last  = 1'b1;
        end else if (b == ChLParen || b == ChLBrace) begin
          a_valid = 1'b1;
          a_last  = fin;
        end else begin
          a_valid = 1'b1;
          a_kind  = KIND_UNKNOWN;
          err     = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (b != ChSlash) begin
          a_valid = 1'b1;
          a_kind  = KIND_UNKNOWN;
          err     = 1'b1;
        end
      end
      MODE_COMMENT: begin
        a_valid = 1'b0;
      end
      MODE_TOKEN: begin
        a_valid = 1'b1;
        a_line  = tok_line_q;
        if (too_long) begin
          a_kind = KIND_TOOLONG;
          a_byte = 8'd0;
          err    = 1'b1;
        end else begin
          a_last = closes || fin;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    mode_d     = mode_q;
    brace_d    = brace_q;
    tok_len_d  = tok_len_q;
    line_step  = line_q;
    tok_line_d = tok_line_q;
    unique case (mode_q)
      MODE_IDLE: begin
        if (is_ws) begin
          if (is_nl) line_step = line_inc;
        end else if (b == ChSlash) begin
          mode_d = MODE_SLASH;
        end else if (b == ChLParen || b == ChLBrace) begin
          tok_line_d = line_q;
          brace_d    = (b == ChLBrace);
          tok_len_d  = 6'd1;
          mode_d     = MODE_TOKEN;
        end
      end
      MODE_SLASH: begin
        mode_d = MODE_COMMENT;
      end
      MODE_COMMENT: begin
        if (is_nl) begin
          line_step = line_inc;
          mode_d    = MODE_IDLE;
        end
      end
      MODE_TOKEN: begin
        if (!too_long) begin
          tok_len_d = tok_len_q + 6'd1;
          if (closes) begin
            mode_d    = MODE_IDLE;
            tok_len_d = 6'd0;
          end
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
    line_d = line_step;
    if (fin) begin
      mode_d     = MODE_IDLE;
      brace_d    = 1'b0;
      tok_len_d  = 6'd0;
      line_d     = 16'd1;
      tok_line_d = 16'd1;
    end else if (err) begin
      mode_d = MODE_ERROR;
    end
  end

  // results: the byte's own result first, then done at the end of the buffer
  logic      done_valid;
  out_item_t a_item, done_item;

  assign done_valid = fin && !err;

  always_comb begin
    a_item.kind          = a_kind;
    a_item.byte_out      = a_byte;
    a_item.line          = a_line;
    a_item.token_last    = a_last;
    a_item.run_last      = !done_valid;
    done_item.kind       = KIND_DONE;
    done_item.byte_out   = 8'd0;
    done_item.line       = line_step;
    done_item.token_last = 1'b0;
    done_item.run_last   = 1'b1;
    if (a_valid) begin
      res_o.valid0 = step_i;
      res_o.valid1 = step_i && done_valid;
      res_o.res0   = a_item;
      res_o.res1   = done_item;
    end else begin
      res_o.valid0 = step_i && done_valid;
      res_o.valid1 = 1'b0;
      res_o.res0   = done_item;
      res_o.res1   = done_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      brace_q    <= 1'b0;
      tok_len_q  <= 6'd0;
      line_q     <= 16'd1;
      tok_line_q <= 16'd1;
    end else if (step_i) begin
      mode_q     <= mode_d;
      brace_q    <= brace_d;
      tok_len_q  <= tok_len_d;
      line_q     <= line_d;
      tok_line_q <= tok_line_d;
    end
  end

endmodule

// ----- src/btl_out_fifo.sv -----
// btl_out_fifo: four-entry result queue, up to two pushes and one pop per cycle
// depends on btl_pkg
module btl_out_fifo import btl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  step_res_t push_i,
  output logic      room2_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  out_item_t   mem_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;
  logic        pop;
  logic [1:0]  n_push;
  logic [1:0]  wr_ptr1;

  assign out_valid_o = (count_q != 3'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room2_o     = (count_q <= 3'd2);
  assign n_push      = {1'b0, push_i.valid0} + {1'b0, push_i.valid1};
  assign wr_ptr1     = wr_ptr_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.valid1) mem_q[wr_ptr1]  <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule

// ----- src/bracket_token_lexer.sv -----
// bracket_token_lexer: one byte per cycle while not stalled; an input transaction passes the input
// register, then the result queue, before its first result. A byte yields at most two results,
// a second only on the buffer's last byte; sustained throughput one byte per cycle unless stalled,
// set by the one-result-per-cycle output port. Reset clears lexer state to line one
// and empties the input register and result queue.
// depends on btl_pkg, btl_lexer, btl_out_fifo
module bracket_token_lexer import btl_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      in_valid_q;
  in_item_t  in_data_q;
  logic      room2;
  logic      step;
  step_res_t res;

  assign step       = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_data_q <= in_data_i;
  end

  btl_lexer #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_lexer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_data_q),
    .res_o (res)
  );

  btl_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .room2_o    (room2),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
